// File: rtl/core/parallel_beam_forward_projector_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the parallel-beam forward projector
// Shared concurrent assertion forms, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef PARALLEL_BEAM_FORWARD_PROJECTOR_TOP_MACROS_SVH
`define PARALLEL_BEAM_FORWARD_PROJECTOR_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define PBFP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pbfp same-cycle assertion failed");
`define PBFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pbfp next-cycle assertion failed");
`else
`define PBFP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PBFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/core/pbfp_pkg.sv
// ----------------------------------------------------------------------------
// pbfp_pkg
// Sizes, word layouts and shared types of the parallel-beam forward projector.
// ----------------------------------------------------------------------------
`default_nettype none

package pbfp_pkg;

    localparam int GRID_SIZE  = 64;
    localparam int ADDR_W     = $clog2(GRID_SIZE);
    localparam int HALF_W     = ADDR_W - 1;
    localparam int BANK_AW    = 2 * HALF_W;
    localparam int BANK_DEPTH = 1 << BANK_AW;
    localparam int NUM_BANKS  = 4;

    localparam int PIX_W  = 16;
    localparam int ROW_W  = 6;
    localparam int BIN_W  = 6;
    localparam int TRIG_W = 16;
    localparam int SUM_W  = 30;

    localparam int FRAC_W   = 14;
    localparam int WEIGHT_W = FRAC_W + 1;
    localparam int ONE_Q14  = 1 << FRAC_W;
    localparam int SUM_FRAC = 8;
    localparam int SHIFT    = 2 * FRAC_W - SUM_FRAC;
    localparam int WZ_W     = 2 * FRAC_W + 1;
    localparam int PROD_W   = WZ_W + PIX_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int SAMPLE_W = ACC_W - SHIFT;

    localparam int SPAN_W  = $clog2(2 * GRID_SIZE) + 1;
    localparam int U_W     = ((BIN_W + 2) > SPAN_W) ? (BIN_W + 2) : SPAN_W;
    localparam int COORD_W = U_W + TRIG_W + 1;
    localparam int POS_W   = ADDR_W + FRAC_W + 1;

    localparam int IN_FIELDS_W  = 2 * ROW_W + PIX_W + 2 * TRIG_W + BIN_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = SUM_W + BIN_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_RAY   = 1'b1;

    typedef struct packed {
        logic [IN_DATA_W-IN_FIELDS_W-1:0] pad;
        logic [BIN_W-1:0]                 detector_bin;
        logic signed [TRIG_W-1:0]         view_msin;
        logic signed [TRIG_W-1:0]         view_cos;
        logic [PIX_W-1:0]                 pixel_value;
        logic [ROW_W-1:0]                 pixel_col;
        logic [ROW_W-1:0]                 pixel_row;
    } in_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_INIT,
        ST_WALK,
        ST_DRAIN,
        ST_LOAD
    } ctrl_state_t;

    typedef struct packed {
        logic                valid;
        logic                first;
        logic                last;
        logic                in_grid;
        logic                a_odd;
        logic                b_odd;
        logic [WEIGHT_W-1:0] c1;
        logic [WEIGHT_W-1:0] c2;
    } sample_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic in_grid;
    } tag_t;

    typedef struct packed {
        logic             ready;
        logic             load;
        logic [BIN_W-1:0] bin;
    } ctrl_status_t;

endpackage

`default_nettype wire

// File: rtl/core/pbfp_pixel_bank.sv
// ----------------------------------------------------------------------------
// pbfp_pixel_bank
// One interleaved bank of the image memory, one write and one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pbfp_pixel_bank (
    input  wire logic                         aclk,
    input  wire logic                         we,
    input  wire logic [pbfp_pkg::BANK_AW-1:0] waddr,
    input  wire logic [pbfp_pkg::PIX_W-1:0]   wdata,
    input  wire logic [pbfp_pkg::BANK_AW-1:0] raddr,
    output logic      [pbfp_pkg::PIX_W-1:0]   rdata
);
    import pbfp_pkg::*;

    logic [PIX_W-1:0] mem [BANK_DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/pbfp_ctrl.sv
// ----------------------------------------------------------------------------
// pbfp_ctrl
// Sequencer: pixel writes, ray setup, sample walk and bank address generation.
// ----------------------------------------------------------------------------
`default_nettype none
`include "parallel_beam_forward_projector_top_macros.svh"

module pbfp_ctrl (
    input  wire logic                                                   aclk,
    input  wire logic                                                   aresetn,
    input  wire logic                                                   in_valid,
    input  wire logic                                                   in_op,
    input  wire pbfp_pkg::in_word_t                                     in_word,
    input  wire logic                                                   out_free,
    input  wire logic                                                   done_i,
    output pbfp_pkg::ctrl_status_t                                      status_o,
    output logic                                                        wr_en,
    output logic [1:0]                                                  wr_bank,
    output logic [pbfp_pkg::BANK_AW-1:0]                                wr_addr,
    output logic [pbfp_pkg::PIX_W-1:0]                                  wr_data,
    output logic [pbfp_pkg::NUM_BANKS-1:0][pbfp_pkg::BANK_AW-1:0]       rd_addr,
    output pbfp_pkg::sample_t                                           samp_o
);
    import pbfp_pkg::*;

    localparam logic signed [COORD_W-1:0] SPAN_C    = COORD_W'(GRID_SIZE - 1);
    localparam logic signed [COORD_W-1:0] LIM_C     = COORD_W'((GRID_SIZE - 1) * ONE_Q14);
    localparam logic signed [COORD_W-1:0] NEG_LIM_C = -LIM_C;
    localparam logic signed [U_W-1:0]     SPAN_U    = U_W'(GRID_SIZE - 1);
    localparam logic [ADDR_W-1:0]         LAST_J    = ADDR_W'(GRID_SIZE - 1);
    localparam logic [ADDR_W-1:0]         EDGE_BASE = ADDR_W'(GRID_SIZE - 2);
    localparam logic [WEIGHT_W-1:0]       ONE_W     = WEIGHT_W'(ONE_Q14);

    ctrl_state_t state_reg, state_next;

    logic signed [TRIG_W-1:0]  cs_reg, cs_next;
    logic signed [TRIG_W-1:0]  ms_reg, ms_next;
    logic [BIN_W-1:0]          bin_reg, bin_next;
    logic signed [COORD_W-1:0] ucs_reg, ucs_next;
    logic signed [COORD_W-1:0] ums_reg, ums_next;
    logic signed [COORD_W-1:0] kcs_reg, kcs_next;
    logic signed [COORD_W-1:0] kms_reg, kms_next;
    logic signed [COORD_W-1:0] x_reg, x_next;
    logic signed [COORD_W-1:0] y_reg, y_next;
    logic [ADDR_W-1:0]         j_reg, j_next;
    sample_t                   samp_reg, samp_next;

    logic                      in_acc;
    logic                      walk;
    logic                      walk_end;
    logic signed [U_W-1:0]     u2;
    logic signed [COORD_W-1:0] u2_c;
    logic signed [COORD_W-1:0] cs_c;
    logic signed [COORD_W-1:0] ms_c;
    logic [ADDR_W-1:0]         a_cur;
    logic [ADDR_W-1:0]         b_cur;
    logic [WEIGHT_W-1:0]       c1_cur;
    logic [WEIGHT_W-1:0]       c2_cur;
    logic                      x_in;
    logic                      y_in;
    logic [ADDR_W-1:0]         row_ext;
    logic [ADDR_W-1:0]         col_ext;

    function automatic logic [ADDR_W+WEIGHT_W-1:0] split_pos(
        input logic signed [COORD_W-1:0] c
    );
        logic [COORD_W-1:0]  s;
        logic [POS_W-1:0]    p;
        logic [ADDR_W-1:0]   base;
        logic [WEIGHT_W-1:0] w;
        s    = c + LIM_C;
        p    = s[POS_W-1:0];
        base = p[POS_W-1:FRAC_W+1];
        w    = WEIGHT_W'(p[FRAC_W:1]);
        if (base >= LAST_J) begin
            base = EDGE_BASE;
            w    = ONE_W;
        end
        return {base, w};
    endfunction

    function automatic logic [HALF_W-1:0] half_idx(
        input logic [ADDR_W-1:0] base,
        input logic              parity
    );
        return base[ADDR_W-1:1] + HALF_W'(base[0] & ~parity);
    endfunction

    assign in_acc   = in_valid && status_o.ready;
    assign walk_end = walk && (j_reg == LAST_J);
    assign u2       = $signed(U_W'({bin_reg, 1'b0})) - SPAN_U;
    assign u2_c     = COORD_W'(u2);
    assign cs_c     = COORD_W'(cs_reg);
    assign ms_c     = COORD_W'(ms_reg);

    assign {a_cur, c1_cur} = split_pos(x_reg);
    assign {b_cur, c2_cur} = split_pos(y_reg);
    assign x_in = (x_reg <= LIM_C) && (x_reg >= NEG_LIM_C);
    assign y_in = (y_reg <= LIM_C) && (y_reg >= NEG_LIM_C);

    assign row_ext = ADDR_W'(in_word.pixel_row);
    assign col_ext = ADDR_W'(in_word.pixel_col);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc && (in_op == OP_RAY)) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                state_next = ST_INIT;
            end
            ST_INIT: begin
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (j_reg == LAST_J) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (done_i) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        status_o.ready = (state_reg == ST_IDLE);
        status_o.load  = (state_reg == ST_LOAD) && out_free;
        status_o.bin   = bin_reg;
        walk           = (state_reg == ST_WALK);
        wr_en          = (state_reg == ST_IDLE) && in_valid && (in_op == OP_WRITE)
                         && (32'(in_word.pixel_row) < 32'(GRID_SIZE))
                         && (32'(in_word.pixel_col) < 32'(GRID_SIZE));
    end

    always_comb begin
        wr_bank = {row_ext[0], col_ext[0]};
        wr_addr = {row_ext[ADDR_W-1:1], col_ext[ADDR_W-1:1]};
        wr_data = in_word.pixel_value;
        for (int bk = 0; bk < NUM_BANKS; bk++) begin
            rd_addr[bk] = {half_idx(a_cur, 1'(bk >> 1)), half_idx(b_cur, 1'(bk))};
        end
    end

    always_comb begin
        cs_next  = cs_reg;
        ms_next  = ms_reg;
        bin_next = bin_reg;
        ucs_next = ucs_reg;
        ums_next = ums_reg;
        kcs_next = kcs_reg;
        kms_next = kms_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        j_next   = j_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc && (in_op == OP_RAY)) begin
                    cs_next  = in_word.view_cos;
                    ms_next  = in_word.view_msin;
                    bin_next = in_word.detector_bin;
                end
            end
            ST_SETUP: begin
                ucs_next = u2_c * cs_c;
                ums_next = u2_c * ms_c;
                kcs_next = SPAN_C * cs_c;
                kms_next = SPAN_C * ms_c;
            end
            ST_INIT: begin
                x_next = ucs_reg + kms_reg;
                y_next = ums_reg - kcs_reg;
                j_next = '0;
            end
            ST_WALK: begin
                x_next = x_reg - (ms_c <<< 1);
                y_next = y_reg + (cs_c <<< 1);
                j_next = j_reg + 1'b1;
            end
            default: begin
                j_next = j_reg;
            end
        endcase

        samp_next.valid   = walk;
        samp_next.first   = (j_reg == '0);
        samp_next.last    = (j_reg == LAST_J);
        samp_next.in_grid = x_in && y_in;
        samp_next.a_odd   = a_cur[0];
        samp_next.b_odd   = b_cur[0];
        samp_next.c1      = c1_cur;
        samp_next.c2      = c2_cur;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            samp_reg  <= '0;
        end else begin
            state_reg <= state_next;
            samp_reg  <= samp_next;
        end
    end

    always_ff @(posedge aclk) begin
        cs_reg  <= cs_next;
        ms_reg  <= ms_next;
        bin_reg <= bin_next;
        ucs_reg <= ucs_next;
        ums_reg <= ums_next;
        kcs_reg <= kcs_next;
        kms_reg <= kms_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        j_reg   <= j_next;
    end

    assign samp_o = samp_reg;

    `PBFP_ASSERT_IMP(a_write_only_idle, aclk, aresetn, wr_en, state_reg == ST_IDLE)
    `PBFP_ASSERT_NEXT(a_walk_ends, aclk, aresetn, walk_end, state_reg == ST_DRAIN)
    `PBFP_ASSERT_IMP(a_done_in_drain, aclk, aresetn, done_i, state_reg == ST_DRAIN)

endmodule

`default_nettype wire

// File: rtl/core/pbfp_blend_acc.sv
// ----------------------------------------------------------------------------
// pbfp_blend_acc
// Bilinear blend pipeline and saturating ray-sum accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module pbfp_blend_acc (
    input  wire logic                                                aclk,
    input  wire logic                                                aresetn,
    input  wire pbfp_pkg::sample_t                                   samp_i,
    input  wire logic [pbfp_pkg::NUM_BANKS-1:0][pbfp_pkg::PIX_W-1:0] rdata,
    output logic                                                     done_o,
    output logic [pbfp_pkg::SUM_W-1:0]                               sum_o
);
    import pbfp_pkg::*;

    localparam logic [WEIGHT_W-1:0] ONE_W = WEIGHT_W'(ONE_Q14);

    tag_t b_tag_reg, b_tag_next;
    tag_t c_tag_reg;
    tag_t d_tag_reg;

    logic [NUM_BANKS-1:0][WZ_W-1:0]   wz_reg, wz_next;
    logic [NUM_BANKS-1:0][PIX_W-1:0]  pix_reg, pix_next;
    logic [NUM_BANKS-1:0][PROD_W-1:0] prod_reg, prod_next;
    logic [SAMPLE_W-1:0]              smp_reg, smp_next;
    logic [SUM_W-1:0]                 sum_reg, sum_next;
    logic                             done_reg, done_next;

    logic [WEIGHT_W-1:0] w0;
    logic [WEIGHT_W-1:0] z0;
    logic [ACC_W-1:0]    acc;
    logic [SUM_W:0]      total;

    assign w0 = ONE_W - samp_i.c1;
    assign z0 = ONE_W - samp_i.c2;

    always_comb begin
        b_tag_next.valid   = samp_i.valid;
        b_tag_next.first   = samp_i.first;
        b_tag_next.last    = samp_i.last;
        b_tag_next.in_grid = samp_i.in_grid;
        for (int t = 0; t < NUM_BANKS; t++) begin
            pix_next[t] = rdata[{samp_i.a_odd ^ 1'(t >> 1), samp_i.b_odd ^ 1'(t)}];
            wz_next[t]  = WZ_W'(1'(t >> 1) ? samp_i.c1 : w0)
                        * WZ_W'(1'(t) ? samp_i.c2 : z0);
        end
    end

    always_comb begin
        for (int t = 0; t < NUM_BANKS; t++) begin
            prod_next[t] = PROD_W'(wz_reg[t]) * PROD_W'(pix_reg[t]);
        end
    end

    always_comb begin
        acc = ACC_W'(prod_reg[0]) + ACC_W'(prod_reg[1])
            + ACC_W'(prod_reg[2]) + ACC_W'(prod_reg[3]);
        smp_next = c_tag_reg.in_grid ? acc[ACC_W-1:SHIFT] : '0;
    end

    always_comb begin
        total     = (d_tag_reg.first ? '0 : {1'b0, sum_reg}) + (SUM_W + 1)'(smp_reg);
        sum_next  = sum_reg;
        if (d_tag_reg.valid) begin
            sum_next = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
        end
        done_next = d_tag_reg.valid && d_tag_reg.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_tag_reg <= '0;
            c_tag_reg <= '0;
            d_tag_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            b_tag_reg <= b_tag_next;
            c_tag_reg <= b_tag_reg;
            d_tag_reg <= c_tag_reg;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        wz_reg   <= wz_next;
        pix_reg  <= pix_next;
        prod_reg <= prod_next;
        smp_reg  <= smp_next;
        sum_reg  <= sum_next;
    end

    assign done_o = done_reg;
    assign sum_o  = sum_reg;

endmodule

`default_nettype wire

// File: rtl/core/parallel_beam_forward_projector_top.sv
// ----------------------------------------------------------------------------
// parallel_beam_forward_projector_top
// Ray-driven parallel-beam forward projector with bilinear interpolation.
// ----------------------------------------------------------------------------
// The slave stream carries one request word at a time. With s_tuser low the
// word writes one pixel of the 64 x 64 image; with s_tuser high it asks for
// the ray sum of one detector bin at the view given by the cosine and minus
// sine. While the sequencer is idle, writes can follow each other every cycle.
// A ray request walks 64 sample points, one per cycle, reading the four
// neighbors of each point from the four interleaved pixel banks in parallel;
// the bank reads and the blend pipeline set the pace. From acceptance until the
// result is loaded into the output register, no new request, pixel write or ray,
// is taken. The master stream returns one word per ray request: the sum with
// eight fraction bits and the detector bin. The result sits in an output
// register; while the receiver stalls, pixel writes are still taken, and a
// following ray holds its result until the register is free. Reset returns
// the sequencer to idle and empties the output register; the image memory is
// not cleared, and every pixel a ray touches must have been written first.
// ----------------------------------------------------------------------------
`default_nettype none
`include "parallel_beam_forward_projector_top_macros.svh"

module parallel_beam_forward_projector_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // pixel_row, pixel_col, pixel_value, view_cos, view_msin, detector_bin
    input  wire logic [pbfp_pkg::IN_DATA_W-1:0]    s_tdata,
    // operation
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // ray_sum, bin_out
    output logic      [pbfp_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import pbfp_pkg::*;

    in_word_t                             in_word;
    ctrl_status_t                         status;
    logic                                 wr_en;
    logic [1:0]                           wr_bank;
    logic [BANK_AW-1:0]                   wr_addr;
    logic [PIX_W-1:0]                     wr_data;
    logic [NUM_BANKS-1:0][BANK_AW-1:0]    rd_addr;
    logic [NUM_BANKS-1:0][PIX_W-1:0]      rdata;
    sample_t                              samp;
    logic                                 done;
    logic [SUM_W-1:0]                     sum;
    logic                                 out_free;

    logic                  m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    assign in_word  = in_word_t'(s_tdata);
    assign out_free = !m_valid_reg || m_tready;

    pbfp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_op    (s_tuser),
        .in_word  (in_word),
        .out_free (out_free),
        .done_i   (done),
        .status_o (status),
        .wr_en    (wr_en),
        .wr_bank  (wr_bank),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_addr  (rd_addr),
        .samp_o   (samp)
    );

    for (genvar bk = 0; bk < NUM_BANKS; bk++) begin : g_bank
        pbfp_pixel_bank u_bank (
            .aclk  (aclk),
            .we    (wr_en && (wr_bank == 2'(bk))),
            .waddr (wr_addr),
            .wdata (wr_data),
            .raddr (rd_addr[bk]),
            .rdata (rdata[bk])
        );
    end

    pbfp_blend_acc u_blend (
        .aclk    (aclk),
        .aresetn (aresetn),
        .samp_i  (samp),
        .rdata   (rdata),
        .done_o  (done),
        .sum_o   (sum)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (status.load) begin
            m_valid_next = 1'b1;
            m_data_next  = OUT_DATA_W'({status.bin, sum});
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign s_tready = status.ready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `PBFP_ASSERT_IMP(a_no_overwrite, aclk, aresetn, status.load, !m_valid_reg || m_tready)

endmodule

`default_nettype wire
